[rtl/barrett_modular_multiplier_unit_defines.svh]
// assertion macros for the barrett modular multiplier unit
`ifndef BARRETT_MODULAR_MULTIPLIER_UNIT_DEFINES_SVH
`define BARRETT_MODULAR_MULTIPLIER_UNIT_DEFINES_SVH

// concurrent check that is switched off while reset is held
`define BMMU_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define BMMU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bmmu_pkg.sv]
// shared types and constants of the barrett modular multiplier unit
`default_nettype none

package bmmu_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = WORD_W / 2;
  localparam int Q_W     = 62;
  localparam int SHIFT_W = 6;
  localparam int RANGE_W = 2;
  localparam int IDX_W   = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODULUS        = 2'd0;
  localparam logic [IDX_W-1:0] REG_BARRETT_FACTOR = 2'd1;
  localparam logic [IDX_W-1:0] REG_PRODUCT_SHIFT  = 2'd2;
  localparam logic [IDX_W-1:0] REG_INPUT_RANGE    = 2'd3;

  // operand range codes
  localparam logic [RANGE_W-1:0] RANGE_BELOW_Q  = 2'd0;
  localparam logic [RANGE_W-1:0] RANGE_BELOW_2Q = 2'd1;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [Q_W-1:0]     modulus;
    logic [WORD_W-1:0]  barrett_factor;
    logic [SHIFT_W-1:0] product_shift;
    logic [RANGE_W-1:0] input_range;
  } cfg_t;

  // data that rides along with a multiply
  typedef struct packed {
    logic [WORD_W-1:0] plo;
    logic              last;
  } side_t;

endpackage

`default_nettype wire

[rtl/bmmu_reduce.sv]
// operand pre-reduction: conditional subtraction of 2q, then of q
`default_nettype none

module bmmu_reduce import bmmu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              i_valid,
  output logic                   o_ready,
  input  wire logic [WORD_W-1:0] i_a,
  input  wire logic [WORD_W-1:0] i_b,
  input  wire logic              i_last,
  output logic                   o_valid,
  input  wire logic              i_ready,
  output logic [WORD_W-1:0]      o_a,
  output logic [WORD_W-1:0]      o_b,
  output logic                   o_last
);

  logic [WORD_W-1:0] q_w;
  logic [WORD_W-1:0] q2_w;
  logic              big_range;
  logic              any_range;

  logic              v1_r, v2_r;
  logic              en1, en2;
  logic [WORD_W-1:0] a1_r, b1_r, a1_nxt, b1_nxt;
  logic [WORD_W-1:0] a2_r, b2_r, a2_nxt, b2_nxt;
  logic              last1_r, last2_r;

  assign q_w       = {{(WORD_W-Q_W){1'b0}}, cfg.modulus};
  assign q2_w      = {{(WORD_W-Q_W-1){1'b0}}, cfg.modulus, 1'b0};
  assign big_range = (cfg.input_range != RANGE_BELOW_Q) &&
                     (cfg.input_range != RANGE_BELOW_2Q);
  assign any_range = (cfg.input_range != RANGE_BELOW_Q);

  // stage enables, a stage loads when empty or when its content moves on
  assign en2     = !v2_r || i_ready;
  assign en1     = !v1_r || en2;
  assign o_ready = en1;

  // first step: subtract 2q for range codes two and three
  always_comb begin
    a1_nxt = (big_range && (i_a >= q2_w)) ? i_a - q2_w : i_a;
    b1_nxt = (big_range && (i_b >= q2_w)) ? i_b - q2_w : i_b;
  end

  // second step: subtract q for any range but the plain one
  always_comb begin
    a2_nxt = (any_range && (a1_r >= q_w)) ? a1_r - q_w : a1_r;
    b2_nxt = (any_range && (b1_r >= q_w)) ? b1_r - q_w : b1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= i_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      a1_r    <= a1_nxt;
      b1_r    <= b1_nxt;
      last1_r <= i_last;
    end
    if (en2) begin
      a2_r    <= a2_nxt;
      b2_r    <= b2_nxt;
      last2_r <= last1_r;
    end
  end

  assign o_valid = v2_r;
  assign o_a     = a2_r;
  assign o_b     = b2_r;
  assign o_last  = last2_r;

endmodule

`default_nettype wire

[rtl/bmmu_mul64.sv]
// 64 by 64 full multiplier: partial products, then their sum
`default_nettype none

module bmmu_mul64 import bmmu_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                i_valid,
  output logic                     o_ready,
  input  wire logic [WORD_W-1:0]   i_x,
  input  wire logic [WORD_W-1:0]   i_y,
  input  wire side_t               i_side,
  output logic                     o_valid,
  input  wire logic                i_ready,
  output logic [2*WORD_W-1:0]      o_p,
  output side_t                    o_side
);

  logic                en1, en2;
  logic                v1_r, v2_r;
  logic [WORD_W-1:0]   ll_r, lh_r, hl_r, hh_r;
  logic [WORD_W-1:0]   ll_nxt, lh_nxt, hl_nxt, hh_nxt;
  logic [2*WORD_W-1:0] p_r, p_nxt;
  side_t               side1_r, side2_r;

  assign en2     = !v2_r || i_ready;
  assign en1     = !v1_r || en2;
  assign o_ready = en1;

  // four 32 by 32 partial products
  always_comb begin
    ll_nxt = i_x[HALF_W-1:0]      * i_y[HALF_W-1:0];
    lh_nxt = i_x[HALF_W-1:0]      * i_y[WORD_W-1:HALF_W];
    hl_nxt = i_x[WORD_W-1:HALF_W] * i_y[HALF_W-1:0];
    hh_nxt = i_x[WORD_W-1:HALF_W] * i_y[WORD_W-1:HALF_W];
  end

  // align and add the partial products
  always_comb begin
    p_nxt = {hh_r, ll_r}
          + {{HALF_W{1'b0}}, lh_r, {HALF_W{1'b0}}}
          + {{HALF_W{1'b0}}, hl_r, {HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= i_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ll_r    <= ll_nxt;
      lh_r    <= lh_nxt;
      hl_r    <= hl_nxt;
      hh_r    <= hh_nxt;
      side1_r <= i_side;
    end
    if (en2) begin
      p_r     <= p_nxt;
      side2_r <= side1_r;
    end
  end

  assign o_valid = v2_r;
  assign o_p     = p_r;
  assign o_side  = side2_r;

endmodule

`default_nettype wire

[rtl/bmmu_fold.sv]
// final reduction: low product minus qhat times q, then two corrections
`default_nettype none

module bmmu_fold import bmmu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              i_valid,
  output logic                   o_ready,
  input  wire logic [WORD_W-1:0] i_qhat,
  input  wire side_t             i_side,
  output logic                   o_valid,
  input  wire logic              i_ready,
  output logic [Q_W-1:0]         o_result,
  output logic                   o_last
);

  logic [WORD_W-1:0] q_w;
  logic [WORD_W-1:0] q2_w;
  logic              en1, en2, en3, en4;
  logic              v1_r, v2_r, v3_r, v4_r;
  logic [WORD_W-1:0] ll_r, ll_nxt;
  logic [HALF_W-1:0] lh_r, hl_r, lh_nxt, hl_nxt;
  logic [WORD_W-1:0] lh_full, hl_full;
  side_t             side1_r;
  logic [WORD_W-1:0] z2_r, z2_nxt, z3_r, z3_nxt, z4_r, z4_nxt;
  logic              last2_r, last3_r, last4_r;

  assign q_w  = {{(WORD_W-Q_W){1'b0}}, cfg.modulus};
  assign q2_w = {{(WORD_W-Q_W-1){1'b0}}, cfg.modulus, 1'b0};

  assign en4     = !v4_r || i_ready;
  assign en3     = !v3_r || en4;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign o_ready = en1;

  // partial products of qhat times q, only the low 64 bits are kept
  always_comb begin
    ll_nxt  = i_qhat[HALF_W-1:0] * q_w[HALF_W-1:0];
    lh_full = i_qhat[HALF_W-1:0] * q_w[WORD_W-1:HALF_W];
    hl_full = i_qhat[WORD_W-1:HALF_W] * q_w[HALF_W-1:0];
    lh_nxt  = lh_full[HALF_W-1:0];
    hl_nxt  = hl_full[HALF_W-1:0];
  end

  // z = plo - qhat * q, modulo 2^64
  always_comb begin
    z2_nxt = side1_r.plo - (ll_r + {lh_r + hl_r, {HALF_W{1'b0}}});
  end

  // corrections by 2q and then by q
  always_comb begin
    z3_nxt = (z2_r >= q2_w) ? z2_r - q2_w : z2_r;
    z4_nxt = (z3_r >= q_w) ? z3_r - q_w : z3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= i_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ll_r    <= ll_nxt;
      lh_r    <= lh_nxt;
      hl_r    <= hl_nxt;
      side1_r <= i_side;
    end
    if (en2) begin
      z2_r    <= z2_nxt;
      last2_r <= side1_r.last;
    end
    if (en3) begin
      z3_r    <= z3_nxt;
      last3_r <= last2_r;
    end
    if (en4) begin
      z4_r    <= z4_nxt;
      last4_r <= last3_r;
    end
  end

  assign o_valid  = v4_r;
  assign o_result = z4_r[Q_W-1:0];
  assign o_last   = last4_r;

endmodule

`default_nettype wire

[rtl/barrett_modular_multiplier_unit.sv]
// top level of the barrett modular multiplier unit
//
//  channel | direction | transfer payload
//  in_     | input     | tdata = first_operand, second_operand; tlast = last_element
//  out_    | output    | tdata = modular_product; tlast = last_out
//  cfg_    | input     | register index and write data, one write per cycle
//
// one item per cycle unless out_ stalls
// stages: 2 operand reduction, 2 product, 1 shift, 2 barrett multiply, 4 fold
// every stage loads when empty or when the next stage takes its content,
// so a stall at out_ holds all data and bubbles are squeezed out
// reset clears the stage valid bits and sets the configuration to defaults
`default_nettype none

module barrett_modular_multiplier_unit import bmmu_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration writes
  input  wire logic                 cfg_wr_en,
  input  wire logic [IDX_W-1:0]     cfg_addr,
  input  wire logic [WORD_W-1:0]    cfg_wdata,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [2*WORD_W-1:0]  in_tdata,   // [63:0] first_operand, [127:64] second_operand
  input  wire logic                 in_tlast,
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [WORD_W-1:0]         out_tdata,  // [61:0] modular_product, [63:62] zero
  output logic                      out_tlast
);

  cfg_t cfg_r;

  logic              red_valid, red_ready, red_last;
  logic [WORD_W-1:0] red_a, red_b;
  side_t             red_side;

  logic                m1_valid, m1_ready;
  logic [2*WORD_W-1:0] m1_p;
  side_t               m1_side;

  logic                sh_en, sh_v_r;
  logic [WORD_W-1:0]   sh_c_r, sh_c_nxt;
  logic [2*WORD_W-1:0] sh_p_shifted;
  side_t               sh_side_r, sh_side_nxt;

  logic                m2_valid, m2_ready;
  logic [2*WORD_W-1:0] m2_p;
  side_t               m2_side;
  side_t               m2_in_side;

  logic                fold_ready;
  logic [Q_W-1:0]      fold_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.modulus        <= Q_W'(4);
      cfg_r.barrett_factor <= '0;
      cfg_r.product_shift  <= SHIFT_W'(1);
      cfg_r.input_range    <= RANGE_BELOW_Q;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MODULUS:        cfg_r.modulus        <= cfg_wdata[Q_W-1:0];
        REG_BARRETT_FACTOR: cfg_r.barrett_factor <= cfg_wdata;
        REG_PRODUCT_SHIFT:  cfg_r.product_shift  <= cfg_wdata[SHIFT_W-1:0];
        REG_INPUT_RANGE:    cfg_r.input_range    <= cfg_wdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // operand pre-reduction
  bmmu_reduce u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .i_valid (in_tvalid),
    .o_ready (in_tready),
    .i_a     (in_tdata[WORD_W-1:0]),
    .i_b     (in_tdata[2*WORD_W-1:WORD_W]),
    .i_last  (in_tlast),
    .o_valid (red_valid),
    .i_ready (red_ready),
    .o_a     (red_a),
    .o_b     (red_b),
    .o_last  (red_last)
  );

  assign red_side.plo  = '0;
  assign red_side.last = red_last;

  // full product of the reduced operands
  bmmu_mul64 u_mul_ab (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (red_valid),
    .o_ready (red_ready),
    .i_x     (red_a),
    .i_y     (red_b),
    .i_side  (red_side),
    .o_valid (m1_valid),
    .i_ready (m1_ready),
    .o_p     (m1_p),
    .o_side  (m1_side)
  );

  // shift stage: c is the low word of the shifted product
  assign sh_en    = !sh_v_r || m2_ready;
  assign m1_ready = sh_en;

  always_comb begin
    sh_p_shifted     = m1_p >> cfg_r.product_shift;
    sh_c_nxt         = sh_p_shifted[WORD_W-1:0];
    sh_side_nxt.plo  = m1_p[WORD_W-1:0];
    sh_side_nxt.last = m1_side.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_v_r <= 1'b0;
    end else if (sh_en) begin
      sh_v_r <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sh_en) begin
      sh_c_r    <= sh_c_nxt;
      sh_side_r <= sh_side_nxt;
    end
  end

  assign m2_in_side = sh_side_r;

  // quotient estimate from the high word of c times the barrett factor
  bmmu_mul64 u_mul_qhat (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (sh_v_r),
    .o_ready (m2_ready),
    .i_x     (sh_c_r),
    .i_y     (cfg_r.barrett_factor),
    .i_side  (m2_in_side),
    .o_valid (m2_valid),
    .i_ready (fold_ready),
    .o_p     (m2_p),
    .o_side  (m2_side)
  );

  // subtraction of qhat times q and final corrections
  bmmu_fold u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .i_valid  (m2_valid),
    .o_ready  (fold_ready),
    .i_qhat   (m2_p[2*WORD_W-1:WORD_W]),
    .i_side   (m2_side),
    .o_valid  (out_tvalid),
    .i_ready  (out_tready),
    .o_result (fold_result),
    .o_last   (out_tlast)
  );

  assign out_tdata = {{(WORD_W-Q_W){1'b0}}, fold_result};

endmodule

`default_nettype wire

[rtl/bmmu_checker.sv]
// port-level checks of the barrett modular multiplier unit and their binding
`default_nettype none
`include "barrett_modular_multiplier_unit_defines.svh"

module bmmu_checker import bmmu_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tready,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [WORD_W-1:0]   out_tdata,
  input wire logic                out_tlast
);

  // a stalled result keeps its payload
  `BMMU_ASSERT_ON(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // the residue never reaches the pad bits
  `BMMU_ASSERT_ON(a_out_pad, clk, rst_n, out_tvalid |-> out_tdata[WORD_W-1:Q_W] == '0, "pad bits of result set")

  // with no result pending the pipeline can always take an item
  `BMMU_ASSERT_ON(a_in_free, clk, rst_n, !out_tvalid |-> in_tready, "input blocked with output idle")

  // reset empties the pipeline
  `BMMU_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind barrett_modular_multiplier_unit bmmu_checker u_bmmu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[tb/tb_barrett_modular_multiplier_unit.sv]
// self-checking testbench of the barrett modular multiplier unit
`default_nettype none

module tb_barrett_modular_multiplier_unit import bmmu_pkg::*;;

  // operand range codes that the package does not name
  localparam logic [RANGE_W-1:0] RANGE_BELOW_4Q = 2'd2;
  localparam logic [RANGE_W-1:0] RANGE_CODE3    = 2'd3;

  localparam int MAX_REPORTS = 10;
  localparam int PIPE_SETTLE = 16;

  // receiver stall patterns
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_TOGGLE
  } ready_mode_t;

  // one expected result
  typedef struct packed {
    logic [Q_W-1:0] product;
    logic           last;
  } residue_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [IDX_W-1:0]    cfg_addr;
  logic [WORD_W-1:0]   cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [2*WORD_W-1:0] in_tdata;   // [63:0] first_operand, [127:64] second_operand
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [WORD_W-1:0]   out_tdata;  // [61:0] modular_product, [63:62] zero
  logic                out_tlast;

  // shadow copy of the configuration registers
  logic [Q_W-1:0]     modulus_q;
  logic [WORD_W-1:0]  barrett_k;
  logic [SHIFT_W-1:0] shift_s;
  logic [RANGE_W-1:0] range_code;

  residue_t    pending_residues[$];
  int          items_sent;
  int          residues_checked;
  int          mismatch_count;
  int          settings_used;
  int          burst_left;
  int          stall_request;
  int          hold_left;
  int          mode_left;
  ready_mode_t ready_mode;

  barrett_modular_multiplier_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // conditional subtraction
  function automatic logic [WORD_W-1:0] drop_if_ge(logic [WORD_W-1:0] v, logic [WORD_W-1:0] m);
    return (v >= m) ? v - m : v;
  endfunction

  // operand pre-reduction; code three acts like the 4q range
  function automatic logic [WORD_W-1:0] prereduce(logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] q;
    q = {2'b00, modulus_q};
    if (range_code == RANGE_BELOW_2Q)
      return drop_if_ge(v, q);
    if (range_code == RANGE_BELOW_4Q || range_code == RANGE_CODE3)
      return drop_if_ge(drop_if_ge(v, q << 1), q);
    return v;
  endfunction

  // barrett product under the current shadow configuration
  function automatic logic [Q_W-1:0] barrett_residue(logic [WORD_W-1:0] x,
                                                     logic [WORD_W-1:0] y);
    logic [WORD_W-1:0]   q;
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
    logic [WORD_W-1:0]   c;
    logic [WORD_W-1:0]   qhat;
    logic [WORD_W-1:0]   z;
    logic [2*WORD_W-1:0] prod;
    logic [2*WORD_W-1:0] shifted;
    logic [2*WORD_W-1:0] ck;
    q = {2'b00, modulus_q};
    a = prereduce(x);
    b = prereduce(y);
    prod = {64'd0, a} * {64'd0, b};
    shifted = prod >> shift_s;
    c = shifted[WORD_W-1:0];
    ck = {64'd0, c} * {64'd0, barrett_k};
    qhat = ck[2*WORD_W-1:WORD_W];
    z = prod[WORD_W-1:0] - qhat * q;
    z = drop_if_ge(drop_if_ge(z, q << 1), q);
    return z[Q_W-1:0];
  endfunction

  // exclusive upper bound of well-formed operands
  function automatic logic [WORD_W-1:0] operand_bound();
    logic [WORD_W-1:0] q;
    q = {2'b00, modulus_q};
    case (range_code)
      RANGE_BELOW_Q:  return q;
      RANGE_BELOW_2Q: return q << 1;
      default:        return q << 2;
    endcase
  endfunction

  // well-formed operand, leaning toward the edges of its range
  function automatic logic [WORD_W-1:0] pick_operand();
    logic [WORD_W-1:0] bound;
    logic [WORD_W-1:0] r;
    bound = operand_bound();
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = bound - 1;
      2: r = {2'b00, modulus_q} - 1;
      3: r = {2'b00, modulus_q} * $urandom_range(0, 3) + $urandom_range(0, 1);
      default: r = {$urandom, $urandom} % bound;
    endcase
    if (r >= bound)
      r = bound - 1;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    residue_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_residues.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result transfer: tdata=%h tlast=%b", out_tdata, out_tlast);
      end else begin
        exp_r = pending_residues.pop_front();
        residues_checked++;
        if (out_tdata !== {2'b00, exp_r.product}) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("modular_product mismatch at result %0d: expected %h, got %h",
                     residues_checked, {2'b00, exp_r.product}, out_tdata);
        end
        if (out_tlast !== exp_r.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("last_out mismatch at result %0d: expected %b, got %b",
                     residues_checked, exp_r.last, out_tlast);
        end
      end
    end
  end

  // receiver: random stall patterns plus requested long hold-offs
  always @(negedge clk) begin
    if (stall_request != 0) begin
      hold_left = stall_request;
      stall_request = 0;
    end
    if (hold_left != 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (ready_mode)
        READY_ALWAYS: out_tready = 1'b1;
        READY_MOSTLY: out_tready = ($urandom_range(0, 3) != 0);
        READY_RARELY: out_tready = ($urandom_range(0, 3) == 0);
        default:      out_tready = ~out_tready;
      endcase
    end
  end

  // one operand pair, sent in bursts with random gaps between them
  task automatic send_operands(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                               input logic last);
    int gap;
    residue_t exp_r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {b, a};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    exp_r.product = barrett_residue(a, b);
    exp_r.last = last;
    pending_residues.push_back(exp_r);
    items_sent++;
    burst_left--;
  endtask

  // stop offering and wait until the pipeline has emptied
  task automatic settle_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // register write; the enable is lowered by finish_writes
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr = idx;
    cfg_wdata = value;
    case (idx)
      REG_MODULUS:        modulus_q = value[Q_W-1:0];
      REG_BARRETT_FACTOR: barrett_k = value;
      REG_PRODUCT_SHIFT:  shift_s = value[SHIFT_W-1:0];
      default:            range_code = value[RANGE_W-1:0];
    endcase
  endtask

  task automatic finish_writes();
    @(negedge clk);
    cfg_wr_en = 1'b0;
    settings_used++;
  endtask

  // consistent setting: shift and factor derived from the modulus
  task automatic program_modulus(input logic [Q_W-1:0] q, input logic [RANGE_W-1:0] range);
    int bw;
    logic [2*WORD_W-1:0] num;
    logic [2*WORD_W-1:0] k;
    bw = 0;
    for (int i = 0; i < Q_W; i++)
      if (q[i])
        bw = i + 1;
    num = 128'd1 << (bw + 62);
    k = num / {66'd0, q};
    settle_pipeline();
    write_reg(REG_MODULUS, {2'b00, q});
    write_reg(REG_BARRETT_FACTOR, k[WORD_W-1:0]);
    write_reg(REG_PRODUCT_SHIFT, 64'(bw - 2));
    write_reg(REG_INPUT_RANGE, {62'd0, range});
    finish_writes();
  endtask

  // random modulus of a random bit width from 3 to 62, so at least 4
  function automatic logic [Q_W-1:0] random_modulus();
    int bw;
    logic [Q_W-1:0] q;
    bw = $urandom_range(3, Q_W);
    q = {$urandom, $urandom};
    q = q & ((62'd1 << bw) - 1);
    q[bw-1] = 1'b1;
    return q;
  endfunction

  // a few items under the reset configuration
  task automatic test_reset_defaults();
    send_operands(64'd3, 64'd3, 1'b0);
    send_operands('1, '1, 1'b1);
    send_operands(64'd0, 64'd5, 1'b0);
  endtask

  // field extremes, every range code, shift corner values
  task automatic test_directed_corners();
    logic [Q_W-1:0] qmax;
    logic [WORD_W-1:0] q64;
    qmax = '1;
    q64 = {2'b00, qmax};
    program_modulus(qmax, RANGE_BELOW_4Q);
    send_operands(64'd0, 64'd0, 1'b0);
    send_operands(q64 - 1, q64 - 1, 1'b1);
    send_operands(q64, q64 << 1, 1'b0);
    send_operands((q64 << 2) - 1, (q64 << 2) - 1, 1'b1);
    send_operands((q64 << 1) - 1, q64 + 1, 1'b0);
    program_modulus(qmax, RANGE_CODE3);
    send_operands((q64 << 2) - 1, (q64 << 1) + 3, 1'b1);
    program_modulus(qmax, RANGE_BELOW_2Q);
    send_operands((q64 << 1) - 1, q64, 1'b0);
    program_modulus(62'd4, RANGE_BELOW_Q);
    send_operands(64'd3, 64'd3, 1'b1);
    program_modulus(62'd4, RANGE_BELOW_2Q);
    send_operands(64'd7, 64'd7, 1'b0);
    program_modulus(62'd1 << 61, RANGE_BELOW_Q);
    send_operands((64'd1 << 61) - 1, (64'd1 << 61) - 1, 1'b1);
    // shift of zero and the largest shift code
    settle_pipeline();
    write_reg(REG_PRODUCT_SHIFT, 64'd0);
    finish_writes();
    send_operands('1, 64'h0123_4567_89ab_cdef, 1'b0);
    send_operands(64'h8000_0000_0000_0001, '1, 1'b1);
    settle_pipeline();
    write_reg(REG_PRODUCT_SHIFT, 64'd63);
    finish_writes();
    send_operands('1, '1, 1'b0);
    send_operands(64'hfedc_ba98_7654_3210, 64'h5555_aaaa_5555_aaaa, 1'b1);
  endtask

  // consistent settings with well-formed operands
  task automatic test_consistent_random(input int settings, input int per_setting);
    logic [Q_W-1:0] q;
    for (int n = 0; n < settings; n++) begin
      case (n)
        0:       q = 62'd4;
        1:       q = '1;
        2:       q = 62'd1 << 61;
        default: q = random_modulus();
      endcase
      program_modulus(q, RANGE_W'(n % 4));
      for (int i = 0; i < per_setting; i++)
        send_operands(pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
    end
  endtask

  // arbitrary register contents and operands anywhere in 64 bits
  task automatic test_wild_random(input int settings, input int per_setting);
    logic [WORD_W-1:0] m;
    for (int n = 0; n < settings; n++) begin
      settle_pipeline();
      // first setting: modulus zero written with the two spare bits set
      m = (n == 0) ? 64'hc000_0000_0000_0000 : {$urandom, $urandom};
      write_reg(REG_MODULUS, m);
      write_reg(REG_BARRETT_FACTOR, (n == 1) ? '1 : {$urandom, $urandom});
      write_reg(REG_PRODUCT_SHIFT, 64'($urandom_range(0, 63)));
      write_reg(REG_INPUT_RANGE, 64'($urandom_range(0, 3)));
      finish_writes();
      for (int i = 0; i < per_setting; i++)
        send_operands({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end
  endtask

  // long receiver hold-off while items keep coming, so the input stalls
  task automatic test_output_hold_off();
    program_modulus(random_modulus(), RANGE_BELOW_4Q);
    send_operands(pick_operand(), pick_operand(), 1'b0);
    stall_request = 300;
    for (int i = 0; i < 150; i++)
      send_operands(pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    program_modulus(random_modulus(), RANGE_BELOW_2Q);
    for (int i = 0; i < 40; i++)
      send_operands(pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
    for (int i = 0; i < 40; i++)
      send_operands(pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
  endtask

  // run limit
  initial begin
    #3_000_000;
    $display("[barrett_modular_multiplier_unit] ERROR");
    $finish;
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b1;
    modulus_q = 62'd4;
    barrett_k = '0;
    shift_s = 6'd1;
    range_code = RANGE_BELOW_Q;
    items_sent = 0;
    residues_checked = 0;
    mismatch_count = 0;
    settings_used = 0;
    burst_left = 0;
    stall_request = 0;
    hold_left = 0;
    mode_left = 0;
    ready_mode = READY_ALWAYS;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_directed_corners();
    test_consistent_random(20, 45);
    test_wild_random(8, 30);
    test_output_hold_off();
    test_drain_pause();
    settle_pipeline();

    if (pending_residues.size() != 0)
      mismatch_count++;
    $display("covered %0d operand pairs over %0d register settings, %0d results checked",
             items_sent, settings_used, residues_checked);
    $display("range codes 0..3, shift 0 and 63, wrap cases, long output hold-off");
    if (mismatch_count == 0) begin
      $display("[barrett_modular_multiplier_unit] OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[barrett_modular_multiplier_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
